FILE: src/tfc_pkg.sv
// Shared types and constants for the triangle flattening / cotangent block.
package tfc_pkg;

  // Field and datapath widths
  localparam int CW    = 32;   // input coordinate
  localparam int EW    = 33;   // edge component
  localparam int PW    = 66;   // edge product
  localparam int CRW   = 67;   // cross product component
  localparam int L2W   = 66;   // squared length of ab
  localparam int DW    = 68;   // dot products
  localparam int SQW   = 136;  // squared cross norm, square root input
  localparam int RTW   = 68;   // square root result
  localparam int SPLIT = 34;   // low part when squaring a cross component
  localparam int SQPW  = 134;  // one squared cross component
  localparam int DVW   = 69;   // divisor
  localparam int QB    = 40;   // quotient bits
  localparam int BUW   = 39;
  localparam int CUW   = 40;
  localparam int CVW   = 39;
  localparam int COTW  = 32;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QAW    = $clog2(QDEPTH);

  // Saturation limits
  localparam logic [QB-1:0]   COT_POS_MAX = 40'h00_7FFF_FFFF;
  localparam logic [QB-1:0]   COT_NEG_MAX = 40'h00_8000_0000;
  localparam logic [QB-1:0]   UV_POS_MAX  = 40'h7F_FFFF_FFFF;
  localparam logic [QB-1:0]   UV_NEG_MAX  = 40'h80_0000_0000;
  localparam logic [COTW-1:0] COT_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [COTW-1:0] COT_NEG_SAT = 32'h8000_0000;
  localparam logic [BUW-1:0]  BU_MAX      = 39'h7F_FFFF_FFFF;

  // One triangle word
  typedef struct packed {
    logic signed [CW-1:0] ax, ay, az;
    logic signed [CW-1:0] bx, by, bz;
    logic signed [CW-1:0] cx, cy, cz;
  } tri_t;

  // Classified work word handed from front to back
  typedef struct packed {
    logic signed [CRW-1:0] cr0, cr1, cr2;
    logic [L2W-1:0]        len2;
    logic signed [DW-1:0]  da, db, dc;
  } work_t;

  // Sideband carried alongside the square roots
  typedef struct packed {
    logic signed [DW-1:0] da, db, dc;
    logic                 degen;
  } sq_side_t;

  // Sideband carried alongside the dividers
  typedef struct packed {
    logic           degen;
    logic           lzero;
    logic           cu_neg;
    logic           a_neg, b_neg, c_neg;
    logic           a_zero, b_zero, c_zero;
    logic [BUW-1:0] bu;
  } dv_side_t;

endpackage

FILE: src/tfc_front.sv
// Front end: edges, cross and dot products of one triangle, three stages.
module tfc_front import tfc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  tri_t  in_tri,
  output logic  wk_valid,
  input  logic  wk_ready,
  output work_t wk
);

  logic v1_r, v2_r, v3_r;
  logic adv1, adv2, adv3;

  logic signed [EW-1:0] e1_r [3];
  logic signed [EW-1:0] e2_r [3];
  logic signed [EW-1:0] e3_r [3];
  logic signed [EW-1:0] e1_nxt [3];
  logic signed [EW-1:0] e2_nxt [3];
  logic signed [EW-1:0] e3_nxt [3];

  logic signed [PW-1:0] xp_r [6];
  logic signed [PW-1:0] ll_r [3];
  logic signed [PW-1:0] aa_r [3];
  logic signed [PW-1:0] bb_r [3];
  logic signed [PW-1:0] cc_r [3];

  work_t wk_r, wk_nxt;
  logic signed [DW-1:0] l2_sum;

  function automatic logic signed [DW-1:0] sum3(input logic signed [PW-1:0] a,
                                                input logic signed [PW-1:0] b,
                                                input logic signed [PW-1:0] c);
    sum3 = DW'(a) + DW'(b) + DW'(c);
  endfunction

  function automatic logic signed [CRW-1:0] sub2(input logic signed [PW-1:0] a,
                                                 input logic signed [PW-1:0] b);
    sub2 = CRW'(a) - CRW'(b);
  endfunction

  // stage advance chain, back to front
  assign adv3     = !v3_r || wk_ready;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_ready = adv1;
  assign wk_valid = v3_r;
  assign wk       = wk_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= in_valid;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
    end
  end

  // stage 1: edge vectors b-a, c-a, c-b
  always_comb begin
    e1_nxt[0] = $signed({in_tri.bx[CW-1], in_tri.bx}) - $signed({in_tri.ax[CW-1], in_tri.ax});
    e1_nxt[1] = $signed({in_tri.by[CW-1], in_tri.by}) - $signed({in_tri.ay[CW-1], in_tri.ay});
    e1_nxt[2] = $signed({in_tri.bz[CW-1], in_tri.bz}) - $signed({in_tri.az[CW-1], in_tri.az});
    e2_nxt[0] = $signed({in_tri.cx[CW-1], in_tri.cx}) - $signed({in_tri.ax[CW-1], in_tri.ax});
    e2_nxt[1] = $signed({in_tri.cy[CW-1], in_tri.cy}) - $signed({in_tri.ay[CW-1], in_tri.ay});
    e2_nxt[2] = $signed({in_tri.cz[CW-1], in_tri.cz}) - $signed({in_tri.az[CW-1], in_tri.az});
    e3_nxt[0] = $signed({in_tri.cx[CW-1], in_tri.cx}) - $signed({in_tri.bx[CW-1], in_tri.bx});
    e3_nxt[1] = $signed({in_tri.cy[CW-1], in_tri.cy}) - $signed({in_tri.by[CW-1], in_tri.by});
    e3_nxt[2] = $signed({in_tri.cz[CW-1], in_tri.cz}) - $signed({in_tri.bz[CW-1], in_tri.bz});
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= e1_nxt[i];
        e2_r[i] <= e2_nxt[i];
        e3_r[i] <= e3_nxt[i];
      end
    end
  end

  // stage 2: one multiplier per product term
  always_ff @(posedge clk) begin
    if (adv2) begin
      xp_r[0] <= e1_r[1] * e2_r[2];
      xp_r[1] <= e1_r[2] * e2_r[1];
      xp_r[2] <= e1_r[2] * e2_r[0];
      xp_r[3] <= e1_r[0] * e2_r[2];
      xp_r[4] <= e1_r[0] * e2_r[1];
      xp_r[5] <= e1_r[1] * e2_r[0];
      for (int i = 0; i < 3; i++) begin
        ll_r[i] <= e1_r[i] * e1_r[i];
        aa_r[i] <= e1_r[i] * e2_r[i];
        bb_r[i] <= e1_r[i] * e3_r[i];
        cc_r[i] <= e2_r[i] * e3_r[i];
      end
    end
  end

  // stage 3: cross components and dot sums
  always_comb begin
    l2_sum      = sum3(ll_r[0], ll_r[1], ll_r[2]);
    wk_nxt.cr0  = sub2(xp_r[0], xp_r[1]);
    wk_nxt.cr1  = sub2(xp_r[2], xp_r[3]);
    wk_nxt.cr2  = sub2(xp_r[4], xp_r[5]);
    wk_nxt.len2 = l2_sum[L2W-1:0];
    wk_nxt.da   = sum3(aa_r[0], aa_r[1], aa_r[2]);
    wk_nxt.db   = -sum3(bb_r[0], bb_r[1], bb_r[2]);
    wk_nxt.dc   = sum3(cc_r[0], cc_r[1], cc_r[2]);
  end

  always_ff @(posedge clk) begin
    if (adv3) wk_r <= wk_nxt;
  end

endmodule

FILE: src/tfc_queue.sv
// Short word queue between front and back.
module tfc_queue import tfc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push_valid,
  output logic  push_ready,
  input  work_t push_data,
  output logic  pop_valid,
  input  logic  pop_ready,
  output work_t pop_data
);

  work_t          mem_r [QDEPTH];
  logic [QAW-1:0] wp_r, rp_r;
  logic [QAW:0]   cnt_r;
  logic           push, pop;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem_r[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= push_data;
  end

endmodule

FILE: src/tfc_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module tfc_sqrt import tfc_pkg::*; (
  input  logic           clk,
  input  logic           en,
  input  logic [SQW-1:0] x,
  output logic [RTW-1:0] root
);

  logic [SQW-1:0]   x_r    [RTW];
  logic [RTW+1:0]   rem_r  [RTW];
  logic [RTW-1:0]   root_r [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stg
    logic [SQW-1:0] x_in;
    logic [RTW+1:0] rem_in;
    logic [RTW-1:0] root_in;
    logic [RTW+3:0] cand, trial;
    logic           ge;

    if (k == 0) begin : g_first
      assign x_in    = x;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // bring down two radicand bits, try root*4+1
    assign cand  = {rem_in, x_in[SQW-1-2*k -: 2]};
    assign trial = (RTW+4)'({root_in, 2'b01});
    assign ge    = (cand >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]    <= x_in;
        rem_r[k]  <= ge ? (RTW+2)'(cand - trial) : (RTW+2)'(cand);
        root_r[k] <= {root_in[RTW-2:0], ge};
      end
    end
  end

  assign root = root_r[RTW-1];

endmodule

FILE: src/tfc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
module tfc_div import tfc_pkg::*; #(
  parameter int NB = 86
) (
  input  logic           clk,
  input  logic           en,
  input  logic [NB-1:0]  n,
  input  logic [DVW-1:0] d,
  output logic [QB-1:0]  q,
  output logic           ovf
);

  localparam int HW = NB - QB;

  logic [QB-1:0]  nlo_r [QB+1];
  logic [DVW-1:0] d_r   [QB+1];
  logic [DVW-1:0] r_r   [QB+1];
  logic [QB-1:0]  q_r   [QB+1];
  logic           ovf_r [QB+1];

  logic [HW-1:0]  hi;
  logic           ovf0;

  // quotient fits in QB bits only when n >> QB is below d
  assign hi   = n[NB-1:QB];
  assign ovf0 = ({{DVW{1'b0}}, hi} >= {{HW{1'b0}}, d});

  always_ff @(posedge clk) begin
    if (en) begin
      nlo_r[0] <= n[QB-1:0];
      d_r[0]   <= d;
      r_r[0]   <= ovf0 ? '0 : DVW'(hi);
      q_r[0]   <= '0;
      ovf_r[0] <= ovf0;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stg
    logic [DVW:0]   t, diff;
    logic           ge;
    logic [QB-1:0]  q_nxt;

    assign t    = {r_r[k-1], nlo_r[k-1][QB-k]};
    assign diff = t - {1'b0, d_r[k-1]};
    assign ge   = (t >= {1'b0, d_r[k-1]});

    always_comb begin
      q_nxt       = q_r[k-1];
      q_nxt[QB-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nlo_r[k] <= nlo_r[k-1];
        d_r[k]   <= d_r[k-1];
        r_r[k]   <= ge ? diff[DVW-1:0] : t[DVW-1:0];
        q_r[k]   <= q_nxt;
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign q   = q_r[QB];
  assign ovf = ovf_r[QB];

endmodule

FILE: src/tfc_back.sv
// Back end: cross norm, square roots, rounded divisions and output register.
module tfc_back import tfc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wk_valid,
  output logic                   wk_ready,
  input  work_t                  wk,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BUW-1:0]         out_b_u,
  output logic signed [CUW-1:0]  out_c_u,
  output logic [CVW-1:0]         out_c_v,
  output logic signed [COTW-1:0] out_cot_a,
  output logic signed [COTW-1:0] out_cot_b,
  output logic signed [COTW-1:0] out_cot_c,
  output logic                   out_degenerate
);

  localparam int NB  = 70 + FRAC_BITS;
  localparam int LAT = 3 + RTW + 1 + QB;
  localparam int HIW = CRW - SPLIT;

  logic en;
  logic vld_r [LAT];
  logic out_valid_r;

  assign en       = !out_valid_r || out_ready;
  assign wk_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < LAT; k++) vld_r[k] <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= wk_valid;
      for (int k = 1; k < LAT; k++) vld_r[k] <= vld_r[k-1];
      out_valid_r <= vld_r[LAT-1];
    end
  end

  // B1: squares of cross components as hi/lo partial products
  logic [CRW-1:0]      mag [3];
  logic [HIW-1:0]      hi  [3];
  logic [SPLIT-1:0]    lo  [3];
  logic [2*HIW-1:0]    hh_r [3];
  logic [HIW+SPLIT-1:0] hl_r [3];
  logic [2*SPLIT-1:0]  ll_r [3];
  logic [L2W-1:0]      len2_1r, len2_2r, len2_3r;
  sq_side_t            sb1_r, sb2_r, sb3_r;

  always_comb begin
    mag[0] = wk.cr0[CRW-1] ? CRW'(-wk.cr0) : CRW'(wk.cr0);
    mag[1] = wk.cr1[CRW-1] ? CRW'(-wk.cr1) : CRW'(wk.cr1);
    mag[2] = wk.cr2[CRW-1] ? CRW'(-wk.cr2) : CRW'(wk.cr2);
    for (int i = 0; i < 3; i++) begin
      hi[i] = mag[i][CRW-1:SPLIT];
      lo[i] = mag[i][SPLIT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        hh_r[i] <= hi[i] * hi[i];
        hl_r[i] <= hi[i] * lo[i];
        ll_r[i] <= lo[i] * lo[i];
      end
      len2_1r     <= wk.len2;
      sb1_r.da    <= wk.da;
      sb1_r.db    <= wk.db;
      sb1_r.dc    <= wk.dc;
      sb1_r.degen <= (wk.cr0 == '0) && (wk.cr1 == '0) && (wk.cr2 == '0);
    end
  end

  // B2: each squared component
  logic [SQPW-1:0] sq_r [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= (SQPW'(hh_r[i]) << (2*SPLIT)) + (SQPW'(hl_r[i]) << (SPLIT+1))
                   + SQPW'(ll_r[i]);
      end
      len2_2r <= len2_1r;
      sb2_r   <= sb1_r;
    end
  end

  // B3: squared cross norm
  logic [SQW-1:0] q3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      q3_r    <= SQW'(sq_r[0]) + SQW'(sq_r[1]) + SQW'(sq_r[2]);
      len2_3r <= len2_2r;
      sb3_r   <= sb2_r;
    end
  end

  // square roots of |ab x ac|^2 and |ab|^2 side by side
  logic [RTW-1:0] w_root, l_root;
  sq_side_t       sqsb_r [RTW];

  tfc_sqrt u_sqrt_w (.clk(clk), .en(en), .x(q3_r),             .root(w_root));
  tfc_sqrt u_sqrt_l (.clk(clk), .en(en), .x(SQW'(len2_3r)),    .root(l_root));

  always_ff @(posedge clk) begin
    if (en) begin
      sqsb_r[0] <= sb3_r;
      for (int k = 1; k < RTW; k++) sqsb_r[k] <= sqsb_r[k-1];
    end
  end

  // divider operands: round(m/d) = floor((2m + d) / 2d)
  sq_side_t       sbs;
  logic [DW-1:0]  ma, mb, mc;
  logic [NB-1:0]  n_cu, n_cv, n_a, n_b, n_c;
  logic [DVW-1:0] d_len, d_w;
  dv_side_t       dv_in;

  assign sbs = sqsb_r[RTW-1];

  always_comb begin
    ma    = sbs.da[DW-1] ? DW'(-sbs.da) : DW'(sbs.da);
    mb    = sbs.db[DW-1] ? DW'(-sbs.db) : DW'(sbs.db);
    mc    = sbs.dc[DW-1] ? DW'(-sbs.dc) : DW'(sbs.dc);
    d_len = {l_root, 1'b0};
    d_w   = {w_root, 1'b0};
    n_cu  = NB'({ma, 1'b0}) + NB'(l_root);
    n_cv  = NB'({w_root, 1'b0}) + NB'(l_root);
    n_a   = (NB'({ma, 1'b0}) << FRAC_BITS) + NB'(w_root);
    n_b   = (NB'({mb, 1'b0}) << FRAC_BITS) + NB'(w_root);
    n_c   = (NB'({mc, 1'b0}) << FRAC_BITS) + NB'(w_root);

    dv_in.degen  = sbs.degen;
    dv_in.lzero  = (l_root == '0);
    dv_in.cu_neg = sbs.da[DW-1];
    dv_in.a_neg  = sbs.da[DW-1];
    dv_in.b_neg  = sbs.db[DW-1];
    dv_in.c_neg  = sbs.dc[DW-1];
    dv_in.a_zero = (sbs.da == '0);
    dv_in.b_zero = (sbs.db == '0);
    dv_in.c_zero = (sbs.dc == '0);
    dv_in.bu     = (l_root > RTW'(BU_MAX)) ? BU_MAX : l_root[BUW-1:0];
  end

  logic [QB-1:0] q_cu, q_cv, q_a, q_b, q_c;
  logic          o_cu, o_cv, o_a, o_b, o_c;
  dv_side_t      dvsb_r [QB+1];

  tfc_div #(.NB(NB)) u_div_cu (.clk(clk), .en(en), .n(n_cu), .d(d_len), .q(q_cu), .ovf(o_cu));
  tfc_div #(.NB(NB)) u_div_cv (.clk(clk), .en(en), .n(n_cv), .d(d_len), .q(q_cv), .ovf(o_cv));
  tfc_div #(.NB(NB)) u_div_a  (.clk(clk), .en(en), .n(n_a),  .d(d_w),   .q(q_a),  .ovf(o_a));
  tfc_div #(.NB(NB)) u_div_b  (.clk(clk), .en(en), .n(n_b),  .d(d_w),   .q(q_b),  .ovf(o_b));
  tfc_div #(.NB(NB)) u_div_c  (.clk(clk), .en(en), .n(n_c),  .d(d_w),   .q(q_c),  .ovf(o_c));

  always_ff @(posedge clk) begin
    if (en) begin
      dvsb_r[0] <= dv_in;
      for (int k = 1; k <= QB; k++) dvsb_r[k] <= dvsb_r[k-1];
    end
  end

  // saturating sign application
  function automatic logic [COTW-1:0] cot_fn(input logic [QB-1:0] q, input logic ovf,
                                             input logic neg, input logic zero,
                                             input logic degen);
    logic [QB-1:0] nq;
    nq = QB'(0) - q;
    if (degen) begin
      if (zero)     cot_fn = '0;
      else if (neg) cot_fn = COT_NEG_SAT;
      else          cot_fn = COT_POS_SAT;
    end else if (neg) begin
      cot_fn = (ovf || q > COT_NEG_MAX) ? COT_NEG_SAT : nq[COTW-1:0];
    end else begin
      cot_fn = (ovf || q > COT_POS_MAX) ? COT_POS_SAT : q[COTW-1:0];
    end
  endfunction

  dv_side_t       dvs;
  logic [CUW-1:0] cu_res;
  logic [QB-1:0]  cv_full;

  assign dvs = dvsb_r[QB];

  always_comb begin
    if (dvs.lzero)       cu_res = '0;
    else if (dvs.cu_neg) cu_res = (o_cu || q_cu > UV_NEG_MAX) ? UV_NEG_MAX : QB'(0) - q_cu;
    else                 cu_res = (o_cu || q_cu > UV_POS_MAX) ? UV_POS_MAX : q_cu;
    if (dvs.lzero)       cv_full = '0;
    else                 cv_full = (o_cv || q_cv > UV_POS_MAX) ? UV_POS_MAX : q_cv;
  end

  // output register
  logic [BUW-1:0]  b_u_r;
  logic [CUW-1:0]  c_u_r;
  logic [CVW-1:0]  c_v_r;
  logic [COTW-1:0] cot_a_r, cot_b_r, cot_c_r;
  logic            degen_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_u_r   <= dvs.bu;
      c_u_r   <= cu_res;
      c_v_r   <= cv_full[CVW-1:0];
      cot_a_r <= cot_fn(q_a, o_a, dvs.a_neg, dvs.a_zero, dvs.degen);
      cot_b_r <= cot_fn(q_b, o_b, dvs.b_neg, dvs.b_zero, dvs.degen);
      cot_c_r <= cot_fn(q_c, o_c, dvs.c_neg, dvs.c_zero, dvs.degen);
      degen_r <= dvs.degen;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_b_u        = b_u_r;
  assign out_c_u        = c_u_r;
  assign out_c_v        = c_v_r;
  assign out_cot_a      = cot_a_r;
  assign out_cot_b      = cot_b_r;
  assign out_cot_c      = cot_c_r;
  assign out_degenerate = degen_r;

endmodule

FILE: src/triangle_flatten_cotan_top.sv
// Throughput: one triangle per cycle unless out_ready holds the pipeline; the square root
// (68 stages) and divider pipelines, one result bit per stage, are all fully pipelined.
// A 2-word queue separates the 3-stage front end from the back end.
// Reset (rst_n low, synchronous) clears valid bits, queue pointers and queue count only.
module triangle_flatten_cotan_top import tfc_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic signed [CW-1:0]   in_ax,
  input  logic signed [CW-1:0]   in_ay,
  input  logic signed [CW-1:0]   in_az,
  input  logic signed [CW-1:0]   in_bx,
  input  logic signed [CW-1:0]   in_by,
  input  logic signed [CW-1:0]   in_bz,
  input  logic signed [CW-1:0]   in_cx,
  input  logic signed [CW-1:0]   in_cy,
  input  logic signed [CW-1:0]   in_cz,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [BUW-1:0]         out_b_u,
  output logic signed [CUW-1:0]  out_c_u,
  output logic [CVW-1:0]         out_c_v,
  output logic signed [COTW-1:0] out_cot_a,
  output logic signed [COTW-1:0] out_cot_b,
  output logic signed [COTW-1:0] out_cot_c,
  output logic                   out_degenerate
);

  tri_t  in_tri;
  work_t wk_f, wk_q;
  logic  f_valid, f_ready, q_valid, q_ready;

  assign in_tri = '{ax: in_ax, ay: in_ay, az: in_az,
                    bx: in_bx, by: in_by, bz: in_bz,
                    cx: in_cx, cy: in_cy, cz: in_cz};

  tfc_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_tri(in_tri),
    .wk_valid(f_valid), .wk_ready(f_ready), .wk(wk_f)
  );

  tfc_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(f_valid), .push_ready(f_ready), .push_data(wk_f),
    .pop_valid(q_valid), .pop_ready(q_ready), .pop_data(wk_q)
  );

  tfc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst_n(rst_n),
    .wk_valid(q_valid), .wk_ready(q_ready), .wk(wk_q),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_b_u(out_b_u), .out_c_u(out_c_u), .out_c_v(out_c_v),
    .out_cot_a(out_cot_a), .out_cot_b(out_cot_b), .out_cot_c(out_cot_c),
    .out_degenerate(out_degenerate)
  );

  // degenerate triangles give only saturated or zero cotangents, checked here on cot_a
  a_deg_cot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |->
      (out_cot_a == COT_POS_SAT || out_cot_a == COT_NEG_SAT || out_cot_a == '0))
    else $error("degenerate word with unsaturated cotangent");

  // zero sine means c lies on the u axis
  a_deg_cv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_c_v == '0)
    else $error("degenerate word with nonzero c_v");

  // zero-length ab implies degenerate and c at the origin
  a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_b_u == '0 |-> out_degenerate && out_c_u == '0 && out_c_v == '0)
    else $error("zero-length edge not flagged");

endmodule

FILE: tb/sv/tb.sv
// Testbench for triangle_flatten_cotan_top: flattening and cotangent prediction with checking.
module tb import tfc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [191:0] wide_t;
  typedef logic [191:0] uwide_t;

  typedef struct {
    logic [BUW-1:0]         b_u;
    logic signed [CUW-1:0]  c_u;
    logic [CVW-1:0]         c_v;
    logic signed [COTW-1:0] cot_a, cot_b, cot_c;
    logic                   degenerate;
  } flat_t;

  localparam int N_RANDOM = 1930;
  localparam int FRAC = 16;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [CW-1:0] in_ax = '0, in_ay = '0, in_az = '0;
  logic signed [CW-1:0] in_bx = '0, in_by = '0, in_bz = '0;
  logic signed [CW-1:0] in_cx = '0, in_cy = '0, in_cz = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [BUW-1:0] out_b_u;
  logic signed [CUW-1:0] out_c_u;
  logic [CVW-1:0] out_c_v;
  logic signed [COTW-1:0] out_cot_a, out_cot_b, out_cot_c;
  logic out_degenerate;

  tri_t  tri_pending[$];
  flat_t flat_expected[$];
  int    n_errors = 0;
  int    n_accepted = 0;
  int    n_checked = 0;
  int    n_degen = 0;
  int    send_idle;
  int    recv_idle;
  bit    in_taken = 1'b0;
  bit    gen_done = 1'b0;

  triangle_flatten_cotan_top #(.FRAC_BITS(FRAC)) u_top (.*);

  always #4 clk = ~clk;

  // integer square root, floor
  function automatic uwide_t isqrt(input uwide_t n);
    uwide_t r, t;
    r = '0;
    for (int k = 95; k >= 0; k--) begin
      t = r | (uwide_t'(1) << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] clip(input uwide_t v, input logic [63:0] lim);
    return (v > uwide_t'(lim)) ? lim : v[63:0];
  endfunction

  // round to nearest, ties away from zero, then saturate by sign
  function automatic logic [63:0] round_div(input wide_t num, input uwide_t d,
                                            input logic [63:0] maxpos,
                                            input logic [63:0] maxneg);
    uwide_t m, qq;
    bit neg;
    neg = num < 0;
    m = neg ? uwide_t'(-num) : uwide_t'(num);
    qq = (2 * m + d) / (2 * d);
    if (neg) return 64'd0 - clip(qq, maxneg);
    return clip(qq, maxpos);
  endfunction

  function automatic logic [31:0] cotangent(input wide_t dot, input uwide_t w, input bit degen);
    logic [63:0] r;
    if (degen) begin
      if (dot == 0) return 32'd0;
      return (dot < 0) ? COT_NEG_SAT : COT_POS_SAT;
    end
    r = round_div(dot <<< FRAC, w, 64'h7FFF_FFFF, 64'h8000_0000);
    return r[31:0];
  endfunction

  function automatic flat_t flatten(input tri_t t);
    wide_t e1[3], e2[3], e3[3], cr[3], pa[3], pb[3], pc[3];
    wide_t sq, l2, da, db, dc;
    uwide_t w, len;
    logic [63:0] tmp;
    flat_t f;
    pa = '{wide_t'(t.ax), wide_t'(t.ay), wide_t'(t.az)};
    pb = '{wide_t'(t.bx), wide_t'(t.by), wide_t'(t.bz)};
    pc = '{wide_t'(t.cx), wide_t'(t.cy), wide_t'(t.cz)};
    for (int i = 0; i < 3; i++) begin
      e1[i] = pb[i] - pa[i];
      e2[i] = pc[i] - pa[i];
      e3[i] = pc[i] - pb[i];
    end
    for (int i = 0; i < 3; i++)
      cr[i] = e1[(i+1)%3] * e2[(i+2)%3] - e1[(i+2)%3] * e2[(i+1)%3];
    sq = cr[0]*cr[0] + cr[1]*cr[1] + cr[2]*cr[2];
    w = isqrt(uwide_t'(sq));
    l2 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
    len = isqrt(uwide_t'(l2));
    da = e1[0]*e2[0] + e1[1]*e2[1] + e1[2]*e2[2];
    db = -(e1[0]*e3[0] + e1[1]*e3[1] + e1[2]*e3[2]);
    dc = e2[0]*e3[0] + e2[1]*e3[1] + e2[2]*e3[2];
    f.degenerate = (sq == 0);
    tmp = clip(len, 64'h7F_FFFF_FFFF);
    f.b_u = tmp[BUW-1:0];
    f.c_u = '0;
    f.c_v = '0;
    if (len != 0) begin
      tmp = round_div(da, len, 64'h7F_FFFF_FFFF, 64'h80_0000_0000);
      f.c_u = tmp[CUW-1:0];
      tmp = round_div(wide_t'(w), len, 64'h7F_FFFF_FFFF, 64'd0);
      f.c_v = tmp[CVW-1:0];
    end
    f.cot_a = cotangent(da, w, f.degenerate);
    f.cot_b = cotangent(db, w, f.degenerate);
    f.cot_c = cotangent(dc, w, f.degenerate);
    return f;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_errors++;
    $display("ERROR %0t word %0d %s: got %h expected %h", $realtime, n_checked, what, got, want);
  endtask

  function automatic tri_t mk(input int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    return t;
  endfunction

  // append one triangle to the pending list
  function automatic void add_tri(input tri_t t);
    tri_pending.insert(tri_pending.size(), t);
  endfunction

  function automatic logic [31:0] rnd_coord(input int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      default: return $signed($urandom_range(32'h0400)) - 32'sh0200;
    endcase
  endfunction

  // stimulus: directed corners then random triangles
  initial begin
    int o, mode, k;
    tri_t t;
    o = 32'h0001_0000;
    add_tri(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
    add_tri(mk(0, 0, 0, o, 0, 0, 0, o, 0));
    add_tri(mk(0, 0, 0, o, 0, 0, o, o, 0));
    add_tri(mk(0, 0, 0, 2*o, 0, 0, o, 0, 0));
    add_tri(mk(0, 0, 0, 0, 0, 0, o, o, o));
    add_tri(mk(5, 5, 5, 9, 9, 9, 5, 5, 5));
    add_tri(mk(0, 0, 0, o, 0, 0, -o, 1, 0));
    add_tri(mk(0, 0, 0, o, 0, 0, o/2, 1, 0));
    add_tri(mk(0, 0, 0, 1, 0, 0, 0, 1, 0));
    add_tri(mk(0, 0, 0, 1, 0, 0, 1, 1, 0));
    add_tri(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    add_tri(mk(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    add_tri(mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF));
    add_tri(mk(-1, -1, -1, -1, -1, -1, -1, -1, -1));
    add_tri(mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 1, 0));
    add_tri(mk(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0,
               32'h8000_0000, 1, 0));
    add_tri(mk(0, 0, 0, 1, 1, 1, 3, 3, 3));
    add_tri(mk(0, 0, 0, 3, 0, 0, 1, 2, 0));
    add_tri(mk(7, -3, 2, 7, -3, 2, 100, 4, -8));
    add_tri(mk(0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 1));
    for (int n = 0; n < N_RANDOM; n++) begin
      mode = $urandom_range(2);
      t = '{rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
            rnd_coord(mode), rnd_coord(mode), rnd_coord(mode), rnd_coord(mode),
            rnd_coord(mode)};
      // every tenth in modes 1 and 2: c on line ab, nearly or exactly degenerate
      if (n % 10 == 0 && mode != 0) begin
        k = $urandom_range(4);
        t.cx = t.ax + k * (t.bx - t.ax) + ($urandom_range(2) - 1);
        t.cy = t.ay + k * (t.by - t.ay);
        t.cz = t.az + k * (t.bz - t.az);
      end
      add_tri(t);
    end
    gen_done = 1'b1;
  end

  // reset
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  // idle rates follow the phase of the run
  always_comb begin
    if (n_accepted < 650) begin
      send_idle = 31; recv_idle = 71;
    end else if (n_accepted < 1300) begin
      send_idle = 71; recv_idle = 31;
    end else begin
      send_idle = 0; recv_idle = 0;
    end
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      out_ready <= ($urandom_range(99) >= recv_idle);
      if (!in_valid || in_taken) begin
        if (tri_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
          automatic tri_t t = tri_pending.pop_front();
          {in_ax, in_ay, in_az} <= {t.ax, t.ay, t.az};
          {in_bx, in_by, in_bz} <= {t.bx, t.by, t.bz};
          {in_cx, in_cy, in_cz} <= {t.cx, t.cy, t.cz};
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: predict on input words, check output words
  always @(posedge clk) begin
    in_taken = rst_n && in_valid && in_ready;
    if (in_taken) begin
      flat_expected.insert(flat_expected.size(),
                           flatten('{in_ax, in_ay, in_az, in_bx, in_by, in_bz,
                                     in_cx, in_cy, in_cz}));
      n_accepted++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (flat_expected.size() == 0) begin
        report("unexpected word", 64'd0, 64'd0);
      end else begin
        automatic flat_t e = flat_expected.pop_front();
        if (out_b_u !== e.b_u) report("b_u", out_b_u, e.b_u);
        if (out_c_u !== e.c_u) report("c_u", out_c_u, e.c_u);
        if (out_c_v !== e.c_v) report("c_v", out_c_v, e.c_v);
        if (out_cot_a !== e.cot_a) report("cot_a", out_cot_a, e.cot_a);
        if (out_cot_b !== e.cot_b) report("cot_b", out_cot_b, e.cot_b);
        if (out_cot_c !== e.cot_c) report("cot_c", out_cot_c, e.cot_c);
        if (out_degenerate !== e.degenerate)
          report("degenerate", out_degenerate, e.degenerate);
        if (e.degenerate) n_degen++;
      end
      n_checked++;
    end
  end

  // end of run
  initial begin
    wait (gen_done && rst_n);
    wait (tri_pending.size() == 0 && !in_valid && flat_expected.size() == 0);
    repeat (300) @(posedge clk);
    $display("tb: %0d triangles sent, %0d words checked", n_accepted, n_checked);
    $display("tb: %0d degenerate words, %0d mismatches", n_degen, n_errors);
    if (n_errors == 0 && flat_expected.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("tb: failure");
    $finish;
  end

endmodule

FILE: triangle_flatten_cotan_top.f
src/tfc_pkg.sv
src/tfc_front.sv
src/tfc_queue.sv
src/tfc_sqrt.sv
src/tfc_div.sv
src/tfc_back.sv
src/triangle_flatten_cotan_top.sv
tb/sv/tb.sv
